/* rtl/cau_pkg.sv */
// shared widths, operation codes and clipping helpers for the complex arithmetic unit
package cau_pkg;

  localparam int DW   = 32;      // width of every operand and result part
  localparam int FB   = 16;      // fraction bits
  localparam int PW   = 2 * DW;  // exact product width
  localparam int SW   = PW + 1;  // exact sum-of-products width
  localparam int QW   = DW + 1;  // quotient bits kept by the divider
  localparam int NDIV = QW;      // divider steps, one quotient bit each

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          sat;
  } clip_t;

  // state carried down the divider steps
  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic [DW-1:0] res_re;
    logic [DW-1:0] res_im;
    logic          sat;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [PW-1:0] den;
    logic [PW-1:0] m_re;
    logic [PW-1:0] m_im;
    logic [PW-1:0] r_re;
    logic [PW-1:0] r_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
  } div_t;

  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  function automatic clip_t clip_sum(input logic signed [DW:0] v);
    clip_t c;
    c.sat = (v[DW] != v[DW-1]);
    c.val = c.sat ? (v[DW] ? MINV : MAXV) : v[DW-1:0];
    return c;
  endfunction

  function automatic clip_t clip_wide(input logic signed [SW-1:0] v);
    clip_t c;
    c.sat = (v[SW-1:DW-1] != {(SW-DW+1){v[DW-1]}});
    c.val = c.sat ? (v[SW-1] ? MINV : MAXV) : v[DW-1:0];
    return c;
  endfunction

  // sign and magnitude quotient to a clipped pattern
  function automatic clip_t clip_quot(input logic neg, input logic ovf,
                                      input logic [QW-1:0] q);
    clip_t         c;
    logic [QW-1:0] lim;
    lim   = neg ? QW'(MINV) : QW'(MAXV);
    c.sat = ovf || (q > lim);
    if (c.sat) begin
      c.val = neg ? MINV : MAXV;
    end else begin
      c.val = neg ? (DW'(0) - q[DW-1:0]) : q[DW-1:0];
    end
    return c;
  endfunction

endpackage

/* rtl/complex_arithmetic_unit.sv */
// complex add, subtract, multiply and divide on signed Q16.16 operands, fully pipelined
//
// One operand pair is taken per cycle unless a stalled output has backed the pipeline up, and each
// result passes through one stage of six 32x32 multipliers, one stage of 65-bit sums,
// one stage of scaling, clipping and divider setup, 33 restoring divider steps
// (one quotient bit each, real and imaginary in parallel) and the output register.
// Add, subtract and multiply travel through the same stages so results stay in
// order. Each stage holds its beat only while the stage after it is full and
// stalled, so bubbles close up and input is still taken while a result waits.
// A divide by zero returns the dividend with div_zero set and saturated clear.
module complex_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic signed [cau_pkg::DW-1:0] a_real,
  input  logic signed [cau_pkg::DW-1:0] a_imag,
  input  logic signed [cau_pkg::DW-1:0] b_real,
  input  logic signed [cau_pkg::DW-1:0] b_imag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [cau_pkg::DW-1:0] res_real,
  output logic signed [cau_pkg::DW-1:0] res_imag,
  output logic                        div_zero,
  output logic                        saturated
);

  localparam int DW   = cau_pkg::DW;
  localparam int PW   = cau_pkg::PW;
  localparam int SW   = cau_pkg::SW;
  localparam int FB   = cau_pkg::FB;
  localparam int NDIV = cau_pkg::NDIV;
  localparam int D0   = 3;             // first divider stage
  localparam int NS   = D0 + NDIV + 1; // stages including output

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  assign en[NS-1] = !v[NS-1] || out_ready;
  genvar g;
  generate
    for (g = 0; g < NS - 1; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: products
  cau_pkg::func_t        s1_func;
  logic signed [DW-1:0]  s1_ar, s1_ai, s1_br, s1_bi;
  logic signed [PW-1:0]  s1_prr, s1_pii, s1_pir, s1_pri, s1_sqr, s1_sqi;
  logic                  s1_dz;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_func <= cau_pkg::func_t'(func);
      s1_ar   <= a_real;
      s1_ai   <= a_imag;
      s1_br   <= b_real;
      s1_bi   <= b_imag;
      s1_prr  <= a_real * b_real;
      s1_pii  <= a_imag * b_imag;
      s1_pir  <= a_imag * b_real;
      s1_pri  <= a_real * b_imag;
      s1_sqr  <= b_real * b_real;
      s1_sqi  <= b_imag * b_imag;
      s1_dz   <= (func == cau_pkg::FUNC_DIV) && (b_real == '0) && (b_imag == '0);
    end
  end

  // stage 2: sums
  cau_pkg::func_t        s2_func;
  logic signed [DW-1:0]  s2_ar, s2_ai;
  logic signed [DW:0]    s2_lin_re, s2_lin_im;
  logic signed [SW-1:0]  s2_mul_re, s2_mul_im, s2_div_re, s2_div_im;
  logic [PW-1:0]         s2_den;
  logic                  s2_dz;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_func <= s1_func;
      s2_ar   <= s1_ar;
      s2_ai   <= s1_ai;
      s2_dz   <= s1_dz;
      if (s1_func == cau_pkg::FUNC_SUB) begin
        s2_lin_re <= (DW+1)'(s1_ar) - (DW+1)'(s1_br);
        s2_lin_im <= (DW+1)'(s1_ai) - (DW+1)'(s1_bi);
      end else begin
        s2_lin_re <= (DW+1)'(s1_ar) + (DW+1)'(s1_br);
        s2_lin_im <= (DW+1)'(s1_ai) + (DW+1)'(s1_bi);
      end
      s2_mul_re <= SW'(s1_prr) - SW'(s1_pii);
      s2_mul_im <= SW'(s1_pir) + SW'(s1_pri);
      s2_div_re <= SW'(s1_prr) + SW'(s1_pii);
      s2_div_im <= SW'(s1_pir) - SW'(s1_pri);
      s2_den    <= s1_sqr + s1_sqi;
    end
  end

  // stage 3: finish add, subtract and multiply; set up the divider
  cau_pkg::div_t d [NDIV+1];
  cau_pkg::div_t s3_next;

  always_comb begin
    logic signed [SW-1:0] sh_re, sh_im;
    logic [SW-1:0]        mg_re, mg_im;
    cau_pkg::clip_t       c_re, c_im;
    sh_re = s2_mul_re >>> FB;
    sh_im = s2_mul_im >>> FB;
    mg_re = s2_div_re[SW-1] ? (SW'(0) - s2_div_re) : s2_div_re;
    mg_im = s2_div_im[SW-1] ? (SW'(0) - s2_div_im) : s2_div_im;
    case (s2_func)
      cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
        c_re = cau_pkg::clip_sum(s2_lin_re);
        c_im = cau_pkg::clip_sum(s2_lin_im);
      end
      cau_pkg::FUNC_MUL: begin
        c_re = cau_pkg::clip_wide(sh_re);
        c_im = cau_pkg::clip_wide(sh_im);
      end
      default: begin
        // dividend goes out unchanged when the divisor is zero
        c_re = '{val: s2_ar, sat: 1'b0};
        c_im = '{val: s2_ai, sat: 1'b0};
      end
    endcase
    s3_next.is_div = (s2_func == cau_pkg::FUNC_DIV) && !s2_dz;
    s3_next.dz     = s2_dz;
    s3_next.res_re = c_re.val;
    s3_next.res_im = c_im.val;
    s3_next.sat    = c_re.sat || c_im.sat;
    s3_next.neg_re = s2_div_re[SW-1];
    s3_next.neg_im = s2_div_im[SW-1];
    s3_next.den    = s2_den;
    s3_next.m_re   = mg_re[PW-1:0];
    s3_next.m_im   = mg_im[PW-1:0];
    // quotient needs no more than QW bits unless it clips anyway
    s3_next.r_re   = mg_re[PW-1:0] >> (NDIV - FB);
    s3_next.r_im   = mg_im[PW-1:0] >> (NDIV - FB);
    s3_next.ovf_re = (mg_re[PW-1:0] >> (NDIV - FB)) >= s2_den;
    s3_next.ovf_im = (mg_im[PW-1:0] >> (NDIV - FB)) >= s2_den;
    s3_next.q_re   = '0;
    s3_next.q_im   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d[0] <= s3_next;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  generate
    for (g = 0; g < NDIV; g++) begin : g_div
      localparam int K = NDIV - 1 - g;
      logic          nb_re, nb_im;
      logic [PW:0]   rs_re, rs_im;
      logic          ge_re, ge_im;
      cau_pkg::div_t nx;

      if (K >= FB) begin : g_bit
        assign nb_re = d[g].m_re[K-FB];
        assign nb_im = d[g].m_im[K-FB];
      end else begin : g_zero
        assign nb_re = 1'b0;
        assign nb_im = 1'b0;
      end

      always_comb begin
        rs_re   = {d[g].r_re, nb_re};
        rs_im   = {d[g].r_im, nb_im};
        ge_re   = rs_re >= {1'b0, d[g].den};
        ge_im   = rs_im >= {1'b0, d[g].den};
        nx      = d[g];
        nx.r_re = ge_re ? PW'(rs_re - {1'b0, d[g].den}) : rs_re[PW-1:0];
        nx.r_im = ge_im ? PW'(rs_im - {1'b0, d[g].den}) : rs_im[PW-1:0];
        nx.q_re = {d[g].q_re[NDIV-2:0], ge_re};
        nx.q_im = {d[g].q_im[NDIV-2:0], ge_im};
      end

      always_ff @(posedge clk) begin
        if (en[D0+g]) begin
          d[g+1] <= nx;
        end
      end
    end
  endgenerate

  // output stage
  cau_pkg::clip_t q_re_c, q_im_c;
  assign q_re_c = cau_pkg::clip_quot(d[NDIV].neg_re, d[NDIV].ovf_re, d[NDIV].q_re);
  assign q_im_c = cau_pkg::clip_quot(d[NDIV].neg_im, d[NDIV].ovf_im, d[NDIV].q_im);

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      div_zero <= d[NDIV].dz;
      if (d[NDIV].is_div) begin
        res_real  <= q_re_c.val;
        res_imag  <= q_im_c.val;
        saturated <= q_re_c.sat || q_im_c.sat;
      end else begin
        res_real  <= d[NDIV].res_re;
        res_imag  <= d[NDIV].res_im;
        saturated <= d[NDIV].sat;
      end
    end
  end

  a_dz_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> !saturated)
    else $error("saturated set on a zero-divisor result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !(|v) |-> in_ready)
    else $error("empty pipeline refuses input");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted beat missing from first stage");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    v[NS-2] && !en[NS-1] |=> v[NS-2])
    else $error("beat lost behind a stalled output");

endmodule

/* test/tb_complex_arithmetic_unit.sv */
// testbench for the complex arithmetic unit: random and directed operand beats checked against a predictor
module tb_complex_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        sat;
  } cplx_res_t;

  class result_board;
    cplx_res_t pending[$];
    int        errors;

    // clip to the signed 32-bit range
    static function logic [31:0] clip_val(input logic signed [127:0] v, inout logic sat);
      if (v > 128'sd2147483647) begin
        sat = 1'b1;
        return cau_pkg::MAXV;
      end
      if (v < -128'sd2147483648) begin
        sat = 1'b1;
        return cau_pkg::MINV;
      end
      return v[31:0];
    endfunction

    // truncate toward zero
    static function logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
      logic signed [127:0] m;
      logic signed [127:0] q;
      m = (n < 0) ? -n : n;
      q = (m <<< 16) / d;
      return (n < 0) ? -q : q;
    endfunction

    function void note_operands(input cau_pkg::func_t f, input logic signed [31:0] ar,
                                input logic signed [31:0] ai, input logic signed [31:0] br,
                                input logic signed [31:0] bi);
      cplx_res_t           e;
      logic signed [127:0] xr, xi, yr, yi, num_re, num_im, den;
      xr = ar; xi = ai; yr = br; yi = bi;
      e.sat = 1'b0;
      e.dz  = 1'b0;
      case (f)
        cau_pkg::FUNC_ADD: begin
          e.re = clip_val(xr + yr, e.sat);
          e.im = clip_val(xi + yi, e.sat);
        end
        cau_pkg::FUNC_SUB: begin
          e.re = clip_val(xr - yr, e.sat);
          e.im = clip_val(xi - yi, e.sat);
        end
        cau_pkg::FUNC_MUL: begin
          e.re = clip_val((xr * yr - xi * yi) >>> 16, e.sat);
          e.im = clip_val((xi * yr + xr * yi) >>> 16, e.sat);
        end
        default: begin
          if (br == 0 && bi == 0) begin
            e.dz = 1'b1;
            e.re = ar;
            e.im = ai;
          end else begin
            den    = yr * yr + yi * yi;
            num_re = xr * yr + xi * yi;
            num_im = xi * yr - xr * yi;
            e.re   = clip_val(div_trunc(num_re, den), e.sat);
            e.im   = clip_val(div_trunc(num_im, den), e.sat);
          end
        end
      endcase
      pending.push_back(e);
    endfunction

    task check_result(input logic [31:0] re, input logic [31:0] im,
                      input logic dz, input logic sat);
      cplx_res_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) report($sformatf("res_real %h, want %h", re, e.re));
      if (im !== e.im) report($sformatf("res_imag %h, want %h", im, e.im));
      if (dz !== e.dz) report($sformatf("div_zero %b, want %b", dz, e.dz));
      if (sat !== e.sat) report($sformatf("saturated %b, want %b", sat, e.sat));
    endtask

    task report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = cau_pkg::FUNC_ADD;
  logic signed [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] res_real, res_imag;
  logic        div_zero, saturated;

  result_board board = new();
  bit          drive_done = 1'b0;
  int          stall_mode = 0;

  complex_arithmetic_unit dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 7))
      0: return cau_pkg::MAXV;
      1: return cau_pkg::MINV;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< 16;
      4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      5: return 32'($signed($urandom_range(0, 32'h7ff))) - 32'sh400;
      default: return $urandom();
    endcase
  endfunction

  // drive one beat and hold it until accepted
  task automatic send_beat(input cau_pkg::func_t f, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    in_valid <= 1'b1;
    func     <= f;
    a_real   <= ar;
    a_imag   <= ai;
    b_real   <= br;
    b_imag   <= bi;
    do @(posedge clk); while (!in_ready);
    board.note_operands(f, ar, ai, br, bi);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: stall pattern changes now and then
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_result(res_real, res_imag, div_zero, saturated);
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    cau_pkg::func_t f;
    int             burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, all operations, zero divisor, real-only operand
    for (int k = 0; k < 4; k++) begin
      f = cau_pkg::func_t'(k);
      send_beat(f, cau_pkg::MAXV, cau_pkg::MAXV, cau_pkg::MAXV, cau_pkg::MAXV);
      send_beat(f, cau_pkg::MINV, cau_pkg::MINV, cau_pkg::MINV, cau_pkg::MINV);
      send_beat(f, cau_pkg::MAXV, cau_pkg::MINV, cau_pkg::MINV, cau_pkg::MAXV);
      send_beat(f, 32'h0001_8000, 32'hfffe_4000, 32'h0000_0001, 32'hffff_ffff);
      send_beat(f, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0);
    end
    send_beat(cau_pkg::FUNC_DIV, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0);
    send_beat(cau_pkg::FUNC_DIV, cau_pkg::MINV, cau_pkg::MAXV, 32'h0, 32'h0);
    send_beat(cau_pkg::FUNC_DIV, cau_pkg::MAXV, 32'h0, 32'h0, 32'h1);
    send_beat(cau_pkg::FUNC_MUL, cau_pkg::MINV, 32'h0, cau_pkg::MINV, 32'h0);
    idle_gap(3);
    for (int n = 0; n < 500; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        f = cau_pkg::func_t'($urandom_range(0, 3));
        if (f == cau_pkg::FUNC_DIV && $urandom_range(0, 15) == 0)
          send_beat(f, pick_part(), pick_part(), '0, '0);
        else
          send_beat(f, pick_part(), pick_part(), pick_part(),
                    $urandom_range(0, 3) == 0 ? 32'h0 : pick_part());
        n++;
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    drive_done = 1'b1;
  end

  initial begin
    wait (drive_done);
    if (board.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
